@@ sv/gbfp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbfp_pkg
// Shared types and constants of the binary navigation frame parser.
// ---------------------------------------------------------------------------
package gbfp_pkg;

    // Sync pair that opens every frame.
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Message codes that carry navigation data.
    localparam logic [7:0] CLASS_NAV   = 8'd1;
    localparam logic [7:0] ID_POSITION = 8'd2;
    localparam logic [7:0] ID_STATUS   = 8'd3;
    localparam logic [7:0] ID_SOLUTION = 8'd6;
    localparam logic [7:0] ID_VELOCITY = 8'd18;

    // Fix state codes.
    localparam logic [1:0] FIX_DETECTING = 2'd0;
    localparam logic [1:0] FIX_NONE      = 2'd1;
    localparam logic [1:0] FIX_2D        = 2'd2;
    localparam logic [1:0] FIX_3D        = 2'd3;

    // Values that mark a held quantity as not yet known.
    localparam logic [31:0] INVALID_ANGLE    = 32'h7FFF_FFFF;
    localparam logic [31:0] INVALID_ALTITUDE = 32'h7FFF_FFFF;
    localparam logic [31:0] INVALID_ACCURACY = 32'hFFFF_FFFF;
    localparam logic [31:0] INVALID_SPEED    = 32'hFFFF_FFFF;
    localparam logic [31:0] INVALID_TIME     = 32'hFFFF_FFFF;

    // Payload bytes kept for decoding: offsets 0 to 27, plus the satellite count.
    localparam int CAP_BYTES  = 28;
    localparam int SAT_OFFSET = 47;

    // Payload offsets of the decoded words.
    localparam int OFF_TOW      = 0;
    localparam int OFF_LON      = 4;
    localparam int OFF_LAT      = 8;
    localparam int OFF_HEIGHT   = 12;
    localparam int OFF_ACCURACY = 20;
    localparam int OFF_FIXTYPE  = 4;
    localparam int OFF_SPEED    = 20;
    localparam int OFF_HEADING  = 24;

    // Heading / 100 as a multiply by a reciprocal: exact for magnitudes up to 2^31.
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;

    // Width of the packed result data.
    localparam int RES_TDATA_W = 280;

    typedef logic [CAP_BYTES-1:0][7:0] cap_bytes_t;

    // One checked frame handed from the parser to the decoder.
    typedef struct packed {
        logic [7:0] msg_class;
        logic [7:0] msg_id;
        cap_bytes_t pay;
        logic [7:0] sat_byte;
    } frame_desc_t;

    // One result item.
    typedef struct packed {
        logic [31:0]        frames_parsed;
        logic [31:0]        ground_speed;
        logic signed [25:0] course;
        logic [7:0]         satellites;
        logic [1:0]         fix_state;
        logic [31:0]        fix_time_ms;
        logic [31:0]        h_accuracy_mm;
        logic signed [31:0] height_mm;
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic [7:0]         msg_id;
        logic [7:0]         msg_class;
    } result_t;

    // Little-endian 32-bit word at a fixed payload offset.
    function automatic logic [31:0] pay_word(input cap_bytes_t p, input int off);
        pay_word = {p[off+3], p[off+2], p[off+1], p[off]};
    endfunction

endpackage
`default_nettype wire

@@ sv/gbfp_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbfp_front
// Byte parser: sync hunt, header, payload capture and Fletcher checksum.
// ---------------------------------------------------------------------------
module gbfp_front #(
    parameter int PAYLOAD_BYTES = 52
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  byte_fire,
    input  wire logic [7:0]            rx_byte,
    output logic                       push,
    output gbfp_pkg::frame_desc_t      push_desc
);

    localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    logic [3:0]            phase_reg, phase_next;
    logic [7:0]            class_reg, class_next;
    logic [7:0]            id_reg, id_next;
    logic [7:0]            sum_a_reg, sum_a_next;
    logic [7:0]            sum_b_reg, sum_b_next;
    logic [15:0]           len_reg, len_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    gbfp_pkg::cap_bytes_t  cap_reg, cap_next;
    logic [7:0]            sat_reg, sat_next;
    logic [7:0]            add_a;
    logic [15:0]           len_full;
    logic                  store_en;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  good;

    // Running Fletcher sums with the current byte added.
    assign add_a    = sum_a_reg + rx_byte;
    assign len_full = {rx_byte, len_reg[7:0]};
    assign store_en = byte_fire && (phase_reg == PH_PAYLOAD)
                      && (cnt_reg < CNT_W'(PAYLOAD_BYTES));
    assign cnt_inc  = store_en ? cnt_reg + 1'b1 : cnt_reg;

    // Parse state update for each transfer.
    always_comb begin
        phase_next = phase_reg;
        class_next = class_reg;
        id_next    = id_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        good       = 1'b0;
        if (byte_fire) begin
            case (phase_reg)
                PH_SYNC1: begin
                    if (rx_byte == gbfp_pkg::SYNC_FIRST) phase_next = PH_SYNC2;
                end
                PH_SYNC2: begin
                    if (rx_byte == gbfp_pkg::SYNC_SECOND) begin
                        phase_next = PH_CLASS;
                    end else if (rx_byte != gbfp_pkg::SYNC_FIRST) begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_CLASS: begin
                    class_next = rx_byte;
                    sum_a_next = rx_byte;
                    sum_b_next = rx_byte;
                    phase_next = PH_ID;
                end
                PH_ID: begin
                    id_next    = rx_byte;
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_next   = {8'd0, rx_byte};
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_next   = len_full;
                    cnt_next   = '0;
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                    if (len_full > 16'(PAYLOAD_BYTES)) begin
                        phase_next = PH_SYNC1;
                    end else if (len_full == 16'd0) begin
                        phase_next = PH_CK_A;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                    cnt_next   = cnt_inc;
                    if (16'(cnt_inc) >= len_reg) phase_next = PH_CK_A;
                end
                PH_CK_A: begin
                    phase_next = (rx_byte == sum_a_reg) ? PH_CK_B : PH_SYNC1;
                end
                PH_CK_B: begin
                    good       = (rx_byte == sum_b_reg);
                    phase_next = PH_SYNC1;
                end
                default: begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    // Capture of the payload bytes that the decoder reads.
    always_comb begin
        cap_next = cap_reg;
        sat_next = sat_reg;
        for (int i = 0; i < gbfp_pkg::CAP_BYTES; i++) begin
            if (store_en && cnt_reg == CNT_W'(i)) cap_next[i] = rx_byte;
        end
        if (store_en && cnt_reg == CNT_W'(gbfp_pkg::SAT_OFFSET)) sat_next = rx_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            class_reg <= '0;
            id_reg    <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            cap_reg   <= '0;
            sat_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            cap_reg   <= cap_next;
            sat_reg   <= sat_next;
        end
    end

    // A frame whose second checksum byte matches goes to the queue.
    assign push               = good;
    assign push_desc.msg_class = class_reg;
    assign push_desc.msg_id    = id_reg;
    assign push_desc.pay       = cap_reg;
    assign push_desc.sat_byte  = sat_reg;

endmodule
`default_nettype wire

@@ sv/gbfp_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbfp_queue
// Two-entry queue of checked frames between parser and decoder.
// ---------------------------------------------------------------------------
module gbfp_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire gbfp_pkg::frame_desc_t push_desc,
    input  wire logic                  pop,
    output logic                       not_empty,
    output logic                       not_full,
    output gbfp_pkg::frame_desc_t      head_desc
);

    gbfp_pkg::frame_desc_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_desc = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule
`default_nettype wire

@@ sv/gbfp_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gbfp_back
// Frame decoder: updates held navigation values and drives the result register.
// ---------------------------------------------------------------------------
module gbfp_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_not_empty,
    input  wire gbfp_pkg::frame_desc_t q_head,
    output logic                       q_pop,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output gbfp_pkg::result_t          res_data
);

    logic                  adv;
    logic [31:0]           head_heading;

    // Stage A: frame taken from the queue, heading magnitude.
    logic                  a_valid_reg;
    gbfp_pkg::frame_desc_t a_desc_reg;
    logic [31:0]           a_mag_reg;
    logic                  a_neg_reg;

    // Stage B: product for the division by 100.
    logic                  b_valid_reg;
    gbfp_pkg::frame_desc_t b_desc_reg;
    logic [63:0]           b_prod_reg;
    logic                  b_neg_reg;

    // Held values.
    logic [31:0] lat_reg, lat_next;
    logic [31:0] lon_reg, lon_next;
    logic [31:0] hgt_reg, hgt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] tow_reg, tow_next;
    logic [1:0]  fix_reg, fix_next;
    logic [7:0]  sats_reg, sats_next;
    logic [25:0] crs_reg, crs_next;
    logic [31:0] spd_reg, spd_next;
    logic [31:0] cnt_reg, cnt_next;

    logic              out_valid_reg;
    gbfp_pkg::result_t out_reg;

    logic [26:0] quot;
    logic [25:0] crs_val;
    logic [7:0]  fix_type;

    // The whole pipeline moves when the result register can take a value.
    assign adv   = !out_valid_reg || res_ready;
    assign q_pop = adv && q_not_empty;
    assign head_heading = gbfp_pkg::pay_word(q_head.pay, gbfp_pkg::OFF_HEADING);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= q_not_empty;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_desc_reg <= q_head;
            a_neg_reg  <= head_heading[31];
            a_mag_reg  <= head_heading[31] ? (~head_heading + 32'd1) : head_heading;
            b_desc_reg <= a_desc_reg;
            b_neg_reg  <= a_neg_reg;
            b_prod_reg <= a_mag_reg * gbfp_pkg::DIV100_MAGIC;
        end
    end

    // Quotient truncated toward zero, then sign restored.
    assign quot    = b_prod_reg[63:gbfp_pkg::DIV100_SHIFT];
    assign crs_val = b_neg_reg ? (~quot[25:0] + 26'd1) : quot[25:0];
    assign fix_type = b_desc_reg.pay[gbfp_pkg::OFF_FIXTYPE];

    // Decode of the frame at the end of the pipeline.
    always_comb begin
        lat_next  = lat_reg;
        lon_next  = lon_reg;
        hgt_next  = hgt_reg;
        acc_next  = acc_reg;
        tow_next  = tow_reg;
        fix_next  = fix_reg;
        sats_next = sats_reg;
        crs_next  = crs_reg;
        spd_next  = spd_reg;
        cnt_next  = cnt_reg;
        if (b_valid_reg) begin
            cnt_next = cnt_reg + 32'd1;
            if (b_desc_reg.msg_class == gbfp_pkg::CLASS_NAV) begin
                case (b_desc_reg.msg_id)
                    gbfp_pkg::ID_POSITION: begin
                        tow_next = gbfp_pkg::pay_word(b_desc_reg.pay, gbfp_pkg::OFF_TOW);
                        lon_next = gbfp_pkg::pay_word(b_desc_reg.pay, gbfp_pkg::OFF_LON);
                        lat_next = gbfp_pkg::pay_word(b_desc_reg.pay, gbfp_pkg::OFF_LAT);
                        hgt_next = gbfp_pkg::pay_word(b_desc_reg.pay, gbfp_pkg::OFF_HEIGHT);
                        acc_next = gbfp_pkg::pay_word(b_desc_reg.pay,
                                                      gbfp_pkg::OFF_ACCURACY);
                    end
                    gbfp_pkg::ID_STATUS: begin
                        if (fix_type == 8'(gbfp_pkg::FIX_2D)) begin
                            fix_next = gbfp_pkg::FIX_2D;
                        end else if (fix_type == 8'(gbfp_pkg::FIX_3D)) begin
                            fix_next = gbfp_pkg::FIX_3D;
                        end else begin
                            fix_next = gbfp_pkg::FIX_NONE;
                        end
                    end
                    gbfp_pkg::ID_SOLUTION: begin
                        sats_next = b_desc_reg.sat_byte;
                    end
                    gbfp_pkg::ID_VELOCITY: begin
                        crs_next = crs_val;
                        spd_next = gbfp_pkg::pay_word(b_desc_reg.pay, gbfp_pkg::OFF_SPEED);
                    end
                    default: begin
                    end
                endcase
            end
            // Any good frame ends the detecting state.
            if (fix_next == gbfp_pkg::FIX_DETECTING) fix_next = gbfp_pkg::FIX_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg       <= gbfp_pkg::INVALID_ANGLE;
            lon_reg       <= gbfp_pkg::INVALID_ANGLE;
            hgt_reg       <= gbfp_pkg::INVALID_ALTITUDE;
            acc_reg       <= gbfp_pkg::INVALID_ACCURACY;
            tow_reg       <= gbfp_pkg::INVALID_TIME;
            fix_reg       <= gbfp_pkg::FIX_DETECTING;
            sats_reg      <= '0;
            crs_reg       <= gbfp_pkg::INVALID_ANGLE[25:0];
            spd_reg       <= gbfp_pkg::INVALID_SPEED;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            lat_reg       <= lat_next;
            lon_reg       <= lon_next;
            hgt_reg       <= hgt_next;
            acc_reg       <= acc_next;
            tow_reg       <= tow_next;
            fix_reg       <= fix_next;
            sats_reg      <= sats_next;
            crs_reg       <= crs_next;
            spd_reg       <= spd_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= b_valid_reg;
        end
    end

    // Result register, loaded with the values after this frame.
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.msg_class     <= b_desc_reg.msg_class;
            out_reg.msg_id        <= b_desc_reg.msg_id;
            out_reg.latitude      <= lat_next;
            out_reg.longitude     <= lon_next;
            out_reg.height_mm     <= hgt_next;
            out_reg.h_accuracy_mm <= acc_next;
            out_reg.fix_time_ms   <= tow_next;
            out_reg.fix_state     <= fix_next;
            out_reg.satellites    <= sats_next;
            out_reg.course        <= crs_next;
            out_reg.ground_speed  <= spd_next;
            out_reg.frames_parsed <= cnt_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule
`default_nettype wire

@@ sv/gnss_binary_frame_parser.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gnss_binary_frame_parser
// Binary navigation frame parser with Fletcher checksum and message decode.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one received byte
//   per transfer, one transfer per cycle. The byte parser hunts for the sync
//   pair, reads the header, keeps the payload bytes that are decoded and checks
//   the two checksum bytes. Each frame that passes goes into a two-entry queue.
//   A three-stage decoder drains the queue, updates the held navigation values
//   and presents one result per good frame on the master channel (m_tvalid,
//   m_tready, m_tdata). Bad or over-long frames give no result.
//   The result is registered through stages A and B and the result register
//   after the frame enters the queue. Throughput: one byte per cycle while
//   s_tready is high; a frame is at least eight bytes long.
//   When the receiver stalls, the decoder holds its result; the parser keeps
//   taking bytes until the queue holds two frames, then s_tready drops.
//   Reset (aresetn low, synchronous) returns the parser to the sync hunt,
//   empties the queue and restores the held values to their invalid markers.
// ---------------------------------------------------------------------------
module gnss_binary_frame_parser #(
    parameter int PAYLOAD_BYTES = 52
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // rx_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // msg_class, msg_id, latitude, longitude, height_mm, h_accuracy_mm,
    // fix_time_ms, fix_state, satellites, course, ground_speed, frames_parsed
    output logic [gbfp_pkg::RES_TDATA_W-1:0]      m_tdata
);

    logic                  byte_fire;
    logic                  push;
    gbfp_pkg::frame_desc_t push_desc;
    logic                  q_not_empty;
    logic                  q_not_full;
    gbfp_pkg::frame_desc_t q_head;
    logic                  q_pop;
    gbfp_pkg::result_t     res;

    assign s_tready  = q_not_full;
    assign byte_fire = s_tvalid && s_tready;

    gbfp_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (s_tdata),
        .push      (push),
        .push_desc (push_desc)
    );

    gbfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .not_full  (q_not_full),
        .head_desc (q_head)
    );

    gbfp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_data    (res)
    );

    // Result fields packed from the lowest bit up, zero-filled to whole bytes.
    assign m_tdata = {4'd0, res.frames_parsed, res.ground_speed, res.course,
                      res.satellites, res.fix_state, res.fix_time_ms,
                      res.h_accuracy_mm, res.height_mm, res.longitude,
                      res.latitude, res.msg_id, res.msg_class};

endmodule
`default_nettype wire
